// ----- sv/sqvg_pkg.sv -----
`timescale 1ns / 1ps
package sqvg_pkg;

   localparam int SLOT_COUNT_DEF = 32;
   localparam int MAX_QUADS_DEF  = 8192;

   localparam int POLY_A = 102944;
   localparam int POLY_B = 42048;
   localparam int POLY_C = 4640;

   localparam logic [3:0]  LAST_STEP   = 4'd11;
   localparam logic [31:0] WHITE_RGBA  = 32'hffff_ffff;
   localparam logic [15:0] UNIT_TILING = 16'h0100;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_SLOTS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BATCH_FULL = 2'd2;

   typedef enum logic [1:0] {
      KIND_SCENE = 2'd0,
      KIND_FLAT  = 2'd1,
      KIND_TEX   = 2'd2,
      KIND_RSVD  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_MUL,
      ST_WB,
      ST_OFFSET,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load_in;
      logic       clr_scene;
      logic       classify;
      logic       mem_rd;
      logic       next_idx;
      logic       hit;
      logic       claim;
      logic       mul;
      logic       wb;
      logic       offset;
      logic       emit;
      logic [3:0] step;
      logic [1:0] corner;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       batch_full;
      logic       idx_end;
      logic       match;
      logic       out_free;
   } sts_type;

endpackage

// ----- sv/sqvg_ctrl.sv -----
`timescale 1ns / 1ps
module sqvg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sqvg_pkg::sts_type   sts,
   output sqvg_pkg::cmd_type   cmd
);

   sqvg_pkg::state_type state_ff, state_in;
   logic [3:0] step_ff;
   logic [1:0] corner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sqvg_pkg::ST_IDLE;
         step_ff   <= '0;
         corner_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == sqvg_pkg::ST_IDLE) begin
            step_ff   <= '0;
            corner_ff <= '0;
         end else begin
            if (state_ff == sqvg_pkg::ST_WB) step_ff <= step_ff + 4'd1;
            if (state_ff == sqvg_pkg::ST_EMIT && sts.out_free) corner_ff <= corner_ff + 2'd1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sqvg_pkg::ST_IDLE:
            if (req_tvalid) state_in = sqvg_pkg::ST_CLASSIFY;
         sqvg_pkg::ST_CLASSIFY: begin
            case (sts.kind)
               sqvg_pkg::KIND_FLAT: state_in = sqvg_pkg::ST_MUL;
               sqvg_pkg::KIND_TEX:
                  state_in = sts.batch_full ? sqvg_pkg::ST_MUL : sqvg_pkg::ST_SRCH_RD;
               default: state_in = sqvg_pkg::ST_IDLE;
            endcase
         end
         sqvg_pkg::ST_SRCH_RD:
            state_in = sts.idx_end ? sqvg_pkg::ST_MUL : sqvg_pkg::ST_SRCH_CMP;
         sqvg_pkg::ST_SRCH_CMP:
            state_in = sts.match ? sqvg_pkg::ST_MUL : sqvg_pkg::ST_SRCH_RD;
         sqvg_pkg::ST_MUL:
            state_in = sqvg_pkg::ST_WB;
         sqvg_pkg::ST_WB:
            state_in = (step_ff == sqvg_pkg::LAST_STEP) ? sqvg_pkg::ST_OFFSET : sqvg_pkg::ST_MUL;
         sqvg_pkg::ST_OFFSET:
            state_in = sqvg_pkg::ST_EMIT;
         sqvg_pkg::ST_EMIT:
            if (sts.out_free)
               state_in = (corner_ff == 2'd3) ? sqvg_pkg::ST_IDLE : sqvg_pkg::ST_OFFSET;
         default: state_in = sqvg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.step   = step_ff;
      cmd.corner = corner_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         sqvg_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         sqvg_pkg::ST_CLASSIFY: begin
            cmd.clr_scene = (sts.kind == sqvg_pkg::KIND_SCENE);
            cmd.classify  = (sts.kind == sqvg_pkg::KIND_FLAT) ||
                            (sts.kind == sqvg_pkg::KIND_TEX);
         end
         sqvg_pkg::ST_SRCH_RD: begin
            cmd.claim  = sts.idx_end;
            cmd.mem_rd = !sts.idx_end;
         end
         sqvg_pkg::ST_SRCH_CMP: begin
            cmd.hit      = sts.match;
            cmd.next_idx = !sts.match;
         end
         sqvg_pkg::ST_MUL:    cmd.mul = 1'b1;
         sqvg_pkg::ST_WB:     cmd.wb = 1'b1;
         sqvg_pkg::ST_OFFSET: cmd.offset = 1'b1;
         sqvg_pkg::ST_EMIT:   cmd.emit = sts.out_free;
         default: ;
      endcase
   end

endmodule

// ----- sv/sqvg_dp.sv -----
`timescale 1ns / 1ps
module sqvg_dp #(
   parameter int SLOT_COUNT = sqvg_pkg::SLOT_COUNT_DEF,
   parameter int MAX_QUADS  = sqvg_pkg::MAX_QUADS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [255:0]       req_tdata,
   input  logic [1:0]         req_tuser,
   output logic [175:0]       rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  sqvg_pkg::cmd_type  cmd,
   output sqvg_pkg::sts_type  sts
);

   localparam int SW = $clog2(SLOT_COUNT + 1);
   localparam int AW = $clog2(SLOT_COUNT);
   localparam int QW = $clog2(MAX_QUADS + 1);

   logic [1:0]         kind_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, size_x_ff, size_y_ff;
   logic [31:0]        pos_z_ff, color_ff, tex_id_ff;
   logic [15:0]        angle_ff, tiling_ff;

   logic [31:0] slot_mem [SLOT_COUNT];
   logic [31:0] rd_ff;
   logic [SW-1:0] slots_used_ff, idx_ff, slot_ff;
   logic [QW-1:0] quad_count_ff;
   logic [1:0]    status_ff;
   logic          batch_full, room;

   logic [16:0]        x2_ff, t_ff;
   logic signed [17:0] sin_ff, cos_ff;
   logic signed [50:0] prod_ff;
   logic signed [48:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [32:0] offx_ff, offy_ff;

   logic               rsp_valid_ff, out_free;
   logic [175:0]       rsp_data_ff;
   logic               rsp_last_ff;

   assign batch_full = (quad_count_ff >= QW'(MAX_QUADS));
   assign room       = (slots_used_ff < SW'(SLOT_COUNT));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign sts.kind       = kind_ff;
   assign sts.batch_full = batch_full;
   assign sts.idx_end    = (idx_ff >= slots_used_ff);
   assign sts.match      = (rd_ff == tex_id_ff);
   assign sts.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         kind_ff   <= req_tuser;
         pos_x_ff  <= req_tdata[31:0];
         pos_y_ff  <= req_tdata[63:32];
         pos_z_ff  <= req_tdata[95:64];
         size_x_ff <= req_tdata[127:96];
         size_y_ff <= req_tdata[159:128];
         angle_ff  <= req_tdata[175:160];
         color_ff  <= req_tdata[207:176];
         tex_id_ff <= req_tdata[239:208];
         tiling_ff <= req_tdata[255:240];
      end
   end

   // slot table, one entry per search step
   always_ff @(posedge clock) begin
      if (cmd.claim && room) slot_mem[slots_used_ff[AW-1:0]] <= tex_id_ff;
      if (cmd.mem_rd) rd_ff <= slot_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff <= SW'(1);
         quad_count_ff <= '0;
      end else if (cmd.clr_scene) begin
         slots_used_ff <= SW'(1);
         quad_count_ff <= '0;
      end else begin
         if (cmd.classify && !batch_full) quad_count_ff <= quad_count_ff + QW'(1);
         if (cmd.claim && room) slots_used_ff <= slots_used_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         slot_ff   <= '0;
         idx_ff    <= SW'(1);
         status_ff <= batch_full ? sqvg_pkg::STATUS_BATCH_FULL : sqvg_pkg::STATUS_OK;
      end
      if (cmd.next_idx) idx_ff <= idx_ff + SW'(1);
      if (cmd.hit) slot_ff <= idx_ff;
      if (cmd.claim) begin
         if (room) slot_ff <= slots_used_ff;
         else status_ff <= sqvg_pkg::STATUS_SLOTS_FULL;
      end
   end

   // quarter-wave argument for sine and cosine
   logic [15:0]        angle_c;
   logic [15:0]        ang_cur;
   logic [16:0]        x_cur, mag;
   logic signed [32:0] op_a;
   logic signed [17:0] op_b;

   assign angle_c = angle_ff + 16'd16384;
   assign ang_cur = (cmd.step < 4'd4) ? angle_ff : angle_c;
   assign x_cur   = ang_cur[14] ? ((17'd16384 - {3'b0, ang_cur[13:0]}) << 2)
                                : ({3'b0, ang_cur[13:0]} << 2);
   assign mag     = prod_ff[32:16];

   always_comb begin
      case (cmd.step) inside
         4'd0, 4'd4: begin op_a = {16'b0, x_cur};        op_b = {1'b0, x_cur}; end
         4'd1, 4'd5: begin op_a = 33'(sqvg_pkg::POLY_C); op_b = {1'b0, x2_ff}; end
         4'd2, 4'd6: begin op_a = {16'b0, t_ff};         op_b = {1'b0, x2_ff}; end
         4'd3, 4'd7: begin op_a = {16'b0, x_cur};        op_b = {1'b0, t_ff};  end
         4'd8:       begin op_a = 33'(size_x_ff);        op_b = cos_ff;        end
         4'd9:       begin op_a = 33'(size_y_ff);        op_b = sin_ff;        end
         4'd10:      begin op_a = 33'(size_y_ff);        op_b = cos_ff;        end
         default:    begin op_a = 33'(size_x_ff);        op_b = sin_ff;        end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= op_a * op_b;
      if (cmd.wb) begin
         case (cmd.step) inside
            4'd0, 4'd4: x2_ff <= mag;
            4'd1, 4'd5: t_ff  <= 17'(sqvg_pkg::POLY_B) - mag;
            4'd2, 4'd6: t_ff  <= 17'(sqvg_pkg::POLY_A) - mag;
            4'd3: sin_ff <= ang_cur[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            4'd7: cos_ff <= ang_cur[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            4'd8:  pa_ff <= prod_ff[48:0];
            4'd9:  pb_ff <= prod_ff[48:0];
            4'd10: pc_ff <= prod_ff[48:0];
            default: pd_ff <= prod_ff[48:0];
         endcase
      end
   end

   // corner offsets, rounded half up to Q16.16
   logic               neg_x, neg_y;
   logic signed [49:0] ta, tb, tc, td, vx, vy, rx, ry;

   assign neg_x = (cmd.corner == 2'd0) || (cmd.corner == 2'd3);
   assign neg_y = !cmd.corner[1];
   assign ta = neg_x ? -50'(pa_ff) : 50'(pa_ff);
   assign tb = neg_y ? -50'(pb_ff) : 50'(pb_ff);
   assign tc = neg_y ? -50'(pc_ff) : 50'(pc_ff);
   assign td = neg_x ? -50'(pd_ff) : 50'(pd_ff);
   assign vx = ta + tb;
   assign vy = tc - td;
   assign rx = (vx + 50'sd65536) >>> 17;
   assign ry = (vy + 50'sd65536) >>> 17;

   always_ff @(posedge clock) begin
      if (cmd.offset) begin
         offx_ff <= rx[32:0];
         offy_ff <= ry[32:0];
      end
   end

   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) sat32 = 32'h7fff_ffff;
      else if (v < -34'sd2147483648) sat32 = 32'h8000_0000;
      else sat32 = v[31:0];
   endfunction

   logic signed [33:0] sum_x, sum_y;
   logic [31:0]        ic_full, vcolor, slot_wide;
   logic [15:0]        vtiling;
   logic               is_tex;

   assign sum_x     = 34'(pos_x_ff) + 34'(offx_ff);
   assign sum_y     = 34'(pos_y_ff) + 34'(offy_ff);
   assign ic_full   = (32'(quad_count_ff) << 2) + (32'(quad_count_ff) << 1);
   assign is_tex    = (kind_ff == sqvg_pkg::KIND_TEX);
   assign vcolor    = is_tex ? sqvg_pkg::WHITE_RGBA : color_ff;
   assign vtiling   = is_tex ? tiling_ff : sqvg_pkg::UNIT_TILING;
   assign slot_wide = 32'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {7'b0, status_ff, ic_full[15:0], vtiling, slot_wide[4:0],
                         cmd.corner[1], (cmd.corner[0] ^ cmd.corner[1]),
                         vcolor, pos_z_ff, sat32(sum_y), sat32(sum_x)};
         rsp_last_ff <= (cmd.corner == 2'd3);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- sv/sprite_quad_vertex_generator.sv -----
`timescale 1ns / 1ps
// A flat quad is classified, then sine, cosine and the four corner products are formed
// on one shared multiplier; each of its four vertices is then offset and emitted in turn.
// A textured quad, unless the batch is full, also compares slot-table entries and claims a slot if none matches.
// Output stalls hold back the vertex emission.
// Only one request is taken at a time; begin-scene and unknown kinds skip the arithmetic.
// Reset: synchronous; quad count 0, one slot in use, output empty.
module sprite_quad_vertex_generator #(
   parameter int SLOT_COUNT = sqvg_pkg::SLOT_COUNT_DEF,
   parameter int MAX_QUADS  = sqvg_pkg::MAX_QUADS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, size_x, size_y, angle, color_rgba, texture_id, tiling
   input  logic [255:0] req_tdata,
   // kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vert_x, vert_y, vert_z, vert_color, tex_u, tex_v, tex_slot, vert_tiling,
   // index_count, status, zero pad
   output logic [175:0] rsp_tdata,
   output logic         rsp_tlast
);

   sqvg_pkg::cmd_type cmd;
   sqvg_pkg::sts_type sts;

   sqvg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sqvg_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .MAX_QUADS  (MAX_QUADS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

`ifndef SYNTHESIS
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("controller stayed ready after taking a request");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("vertex loaded over an unaccepted vertex");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.emit))
      else $error("output valid without a vertex load");
`endif

endmodule
